/* hw/rtl/tcc_pkg.sv */
package tcc_pkg;

  // field widths
  localparam int unsigned POS_W      = 12;
  localparam int unsigned SUM_W      = POS_W + 2;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SCALE_MAX  = 15;
  localparam int unsigned SPACE_MAX  = 15;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_SCALE   = 3'd2,
    REG_SPACING = 3'd3,
    REG_BG      = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [POS_W-1:0]   WIDTH_RESET   = 12'd1024;
  localparam logic [POS_W-1:0]   HEIGHT_RESET  = 12'd768;
  localparam logic [3:0]         SCALE_RESET   = 4'd2;
  localparam logic [3:0]         SPACING_RESET = 4'd1;
  localparam logic [COLOR_W-1:0] BG_RESET      = 24'h000000;
  localparam logic [COLOR_W-1:0] TEXT_RESET    = 24'hFFFFFF;

  // draw command codes
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_FILL   = 2'd3
  } cmd_code_t;

  // byte codes
  localparam logic [7:0] CHAR_NUL    = 8'd0;
  localparam logic [7:0] COLOR_FIRST = 8'd1;
  localparam logic [7:0] COLOR_LAST  = 8'd9;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_BS     = 8'd127;

  // white, black, red, green, blue, yellow, cyan, magenta, gray
  localparam logic [COLOR_W-1:0] PALETTE [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080
  };

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic bs_emit;
    logic scroll_emit;
  } tcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_out;
    logic need_div;
    logic need_scroll;
    logic out_free;
    logic div_busy;
  } tcc_status_t;

endpackage

/* hw/rtl/tcc_if.sv */
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] text_byte;

  modport source (output valid, mode, text_byte, input ready);
  modport sink (input valid, mode, text_byte, output ready);
endinterface

interface tcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  glyph_code;
  logic [23:0] color;
  logic [11:0] scroll_amount;
  logic        last_of_run;

  modport source (output valid, command, pos_x, pos_y, glyph_code, color, scroll_amount,
                  last_of_run, input ready);
  modport sink (input valid, command, pos_x, pos_y, glyph_code, color, scroll_amount,
                last_of_run, output ready);
endinterface

/* hw/rtl/tcc_rem.sv */
module tcc_rem #(
  parameter int unsigned NUM_W = 12,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [DEN_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // one restoring step: bring down next dividend bit, subtract if it fits
  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // partial remainder and shifted dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_q  <= den;
      rem    <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (rem < den_q))
    else $error("remainder not below divisor");
`endif

endmodule

/* hw/rtl/tcc_ctrl.sv */
module tcc_ctrl import tcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  tcc_status_t st,
  output tcc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_BS_EMIT,
    S_SCROLL
  } state_t;

  state_t state_q;
  state_t state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state_q;
    in_ready   = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (!st.need_out || st.out_free) begin
          cmd.exec   = 1'b1;
          state_next = st.need_scroll ? S_SCROLL : S_IDLE;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          state_next = S_BS_EMIT;
        end
      end
      S_BS_EMIT: begin
        if (st.out_free) begin
          cmd.bs_emit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCROLL: begin
        if (st.out_free) begin
          cmd.scroll_emit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_next;
    end
  end

`ifndef SYNTHESIS
  // a result is only committed when the output slot can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.bs_emit || cmd.scroll_emit || (cmd.exec && st.need_out)) |-> st.out_free)
    else $error("result committed while output slot full");

  // remainder unit is running right after it was started
  a_div_run: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (st.div_busy && state_q == S_DIV))
    else $error("remainder unit did not start");
`endif

endmodule

/* hw/rtl/tcc_dp.sv */
module tcc_dp import tcc_pkg::*; #(
  parameter int unsigned FONT_WIDTH  = 8,
  parameter int unsigned FONT_HEIGHT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tcc_cmd_t              cmd,
  output tcc_status_t           st,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_mode,
  input  logic [7:0]            in_byte,
  tcc_out_if.source             out_ch
);

  localparam int unsigned GW_W = $clog2(FONT_WIDTH * SCALE_MAX + 1);
  localparam int unsigned SX_W = $clog2(FONT_WIDTH * SCALE_MAX + SPACE_MAX + 1);
  localparam int unsigned GH_W = $clog2(FONT_HEIGHT * SCALE_MAX + 1);
  localparam int unsigned SY_W = $clog2(FONT_HEIGHT * SCALE_MAX + 2);

  typedef enum logic [2:0] {
    K_FILL,
    K_IGNORE,
    K_COLOR,
    K_CR,
    K_LF,
    K_BS,
    K_DRAW
  } kind_t;

  // configuration registers
  logic [POS_W-1:0]   width_q;
  logic [POS_W-1:0]   height_q;
  logic [3:0]         scale_q;
  logic [3:0]         spacing_q;
  logic [COLOR_W-1:0] bg_q;

  // geometry
  logic [3:0]         scale_eff;
  logic [GW_W-1:0]    gw_next;
  logic [GH_W-1:0]    gh_next;
  logic [SX_W-1:0]    sx_next;
  logic [SY_W-1:0]    sy_next;
  logic [SX_W-1:0]    sx_q;
  logic [SY_W-1:0]    sy_q;
  logic [SUM_W-1:0]   x_reach_q;
  logic [SUM_W-1:0]   y_reach_q;

  // cursor and item
  logic [POS_W-1:0]   x_q;
  logic [POS_W-1:0]   y_q;
  logic [COLOR_W-1:0] color_q;
  logic [POS_W-1:0]   x_next;
  logic [POS_W-1:0]   y_next;
  logic [COLOR_W-1:0] color_next;
  logic               mode_q;
  logic [7:0]         byte_q;
  kind_t              kind;

  // decisions
  logic [SUM_W-1:0]   x_adv;
  logic [SUM_W-1:0]   y_adv;
  logic               draw_wrap;
  logic               y_over;
  logic               bs_step;
  logic               bs_up;
  logic               div_busy;
  logic [SX_W-1:0]    rem;
  logic [POS_W-1:0]   bs_wrap_x;

  // result select
  logic               load;
  cmd_code_t          res_cmd;
  logic [POS_W-1:0]   res_x;
  logic [POS_W-1:0]   res_y;
  logic [7:0]         res_glyph;
  logic [COLOR_W-1:0] res_color;
  logic [POS_W-1:0]   res_amount;
  logic               res_last;

  // output register
  logic               out_valid;
  cmd_code_t          out_cmd;
  logic [POS_W-1:0]   out_x;
  logic [POS_W-1:0]   out_y;
  logic [7:0]         out_glyph;
  logic [COLOR_W-1:0] out_color;
  logic [POS_W-1:0]   out_amount;
  logic               out_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      scale_q   <= SCALE_RESET;
      spacing_q <= SPACING_RESET;
      bg_q      <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:   width_q   <= cfg_data[POS_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_data[POS_W-1:0];
        REG_SCALE:   scale_q   <= cfg_data[3:0];
        REG_SPACING: spacing_q <= cfg_data[3:0];
        REG_BG:      bg_q      <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // glyph and step sizes, a zero scale acts as one
  always_comb begin
    scale_eff = (scale_q == 4'd0) ? 4'd1 : scale_q;
    gw_next   = GW_W'(FONT_WIDTH) * GW_W'(scale_eff);
    gh_next   = GH_W'(FONT_HEIGHT) * GH_W'(scale_eff);
    sx_next   = SX_W'(gw_next) + SX_W'(spacing_q);
    sy_next   = SY_W'(gh_next) + SY_W'(1);
  end

  always_ff @(posedge clk) begin
    sx_q      <= sx_next;
    sy_q      <= sy_next;
    x_reach_q <= SUM_W'(sx_next) + SUM_W'(gw_next);
    y_reach_q <= SUM_W'(sy_next) + SUM_W'(gh_next);
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= in_mode;
      byte_q <= in_byte;
    end
  end

  // byte decode
  always_comb begin
    if (mode_q) begin
      kind = K_FILL;
    end else begin
      case (byte_q) inside
        CHAR_NUL:                  kind = K_IGNORE;
        [COLOR_FIRST:COLOR_LAST]:  kind = K_COLOR;
        CHAR_CR:                   kind = K_CR;
        CHAR_LF:                   kind = K_LF;
        CHAR_BS:                   kind = K_BS;
        default:                   kind = K_DRAW;
      endcase
    end
  end

  // cursor tests
  always_comb begin
    x_adv     = SUM_W'(x_q) + SUM_W'(sx_q);
    y_adv     = SUM_W'(y_q) + SUM_W'(sy_q);
    draw_wrap = (SUM_W'(x_q) + x_reach_q) > SUM_W'(width_q);
    y_over    = (SUM_W'(y_q) + y_reach_q) > SUM_W'(height_q);
    bs_step   = SUM_W'(x_q) >= SUM_W'(sx_q);
    bs_up     = SUM_W'(y_q) >= SUM_W'(sy_q);
  end

  // width mod step for backspace onto the previous line
  tcc_rem #(
    .NUM_W (POS_W),
    .DEN_W (SX_W)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (width_q),
    .den   (sx_q),
    .busy  (div_busy),
    .rem   (rem)
  );

  // last full column: width minus remainder minus one step, or zero
  assign bs_wrap_x = (width_q >= POS_W'(sx_q)) ?
                     (width_q - POS_W'(rem) - POS_W'(sx_q)) : '0;

  // status
  always_comb begin
    st.need_out    = (kind == K_FILL) || (kind == K_BS) || (kind == K_DRAW) ||
                     ((kind == K_LF) && y_over);
    st.need_div    = (kind == K_BS) && !bs_step && bs_up;
    st.need_scroll = (kind == K_DRAW) && draw_wrap && y_over;
    st.out_free    = !out_valid || out_ch.ready;
    st.div_busy    = div_busy;
  end

  // result and next cursor
  always_comb begin
    load       = 1'b0;
    res_cmd    = CMD_DRAW;
    res_x      = '0;
    res_y      = '0;
    res_glyph  = '0;
    res_color  = bg_q;
    res_amount = '0;
    res_last   = 1'b1;
    x_next     = x_q;
    y_next     = y_q;
    color_next = color_q;
    if (cmd.bs_emit) begin
      load    = 1'b1;
      res_cmd = CMD_CLEAR;
      x_next  = bs_wrap_x;
      y_next  = y_q - POS_W'(sy_q);
      res_x   = x_next;
      res_y   = y_next;
    end else if (cmd.scroll_emit) begin
      load       = 1'b1;
      res_cmd    = CMD_SCROLL;
      res_amount = POS_W'(sy_q);
    end else if (cmd.exec) begin
      case (kind)
        K_FILL: begin
          load    = 1'b1;
          res_cmd = CMD_FILL;
          x_next  = '0;
          y_next  = '0;
        end
        K_COLOR: begin
          color_next = PALETTE[byte_q[3:0] - 4'd1];
        end
        K_CR: begin
          x_next = '0;
        end
        K_LF: begin
          x_next = '0;
          if (y_over) begin
            load       = 1'b1;
            res_cmd    = CMD_SCROLL;
            res_amount = POS_W'(sy_q);
          end else begin
            y_next = y_adv[POS_W-1:0];
          end
        end
        K_BS: begin
          load    = 1'b1;
          res_cmd = CMD_CLEAR;
          if (bs_step) begin
            x_next = x_q - POS_W'(sx_q);
          end else begin
            x_next = '0;
            y_next = '0;
          end
          res_x = x_next;
          res_y = y_next;
        end
        K_DRAW: begin
          load      = 1'b1;
          res_cmd   = CMD_DRAW;
          res_x     = x_q;
          res_y     = y_q;
          res_glyph = byte_q;
          res_color = color_q;
          res_last  = !(draw_wrap && y_over);
          if (draw_wrap) begin
            x_next = '0;
            if (!y_over) begin
              y_next = y_adv[POS_W-1:0];
            end
          end else begin
            x_next = x_adv[POS_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_q     <= '0;
      y_q     <= '0;
      color_q <= TEXT_RESET;
    end else begin
      x_q     <= x_next;
      y_q     <= y_next;
      color_q <= color_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd    <= res_cmd;
      out_x      <= res_x;
      out_y      <= res_y;
      out_glyph  <= res_glyph;
      out_color  <= res_color;
      out_amount <= res_amount;
      out_last   <= res_last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.command       = out_cmd;
  assign out_ch.pos_x         = out_x;
  assign out_ch.pos_y         = out_y;
  assign out_ch.glyph_code    = out_glyph;
  assign out_ch.color         = out_color;
  assign out_ch.scroll_amount = out_amount;
  assign out_ch.last_of_run   = out_last;

`ifndef SYNTHESIS
  // clearing the screen homes the cursor
  a_fill_home: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && kind == K_FILL) |=> (x_q == '0 && y_q == '0))
    else $error("cursor not homed after fill");

  // only a draw can be followed by a further result of the same request
  a_last_draw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_cmd == CMD_DRAW))
    else $error("non-final result that is not a draw");
`endif

endmodule

/* hw/rtl/text_console_cursor_engine.sv */
// Text console cursor engine: turns text requests into framebuffer draw commands.
// Input channel in_ch carries mode and text_byte; a request is taken on a clock
// edge with valid and ready high. Output channel out_ch carries one draw command
// per transfer; a request yields zero, one or two commands, the final one marked
// by last_of_run. Registers are to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle, which the block does not enforce: 0 width,
// 1 height, 2 glyph scale, 3 char spacing, 4 background color; other indexes
// are ignored. A request is captured into a register, then decoded and executed
// in the execute state, which waits while the output register is full; its first
// command is then loaded into the output register. A draw that wraps and scrolls
// also passes a scroll state; a backspace that steps onto the previous line waits
// for the 12-step width-mod-step remainder unit that finds the last column.
// An output register sits between the engine and the receiver, so the next
// request is taken while a finished command still waits. When the receiver
// stalls, the engine holds its next command in the execute stage until the
// register frees up. Reset (synchronous, active high) restores the register
// defaults, homes the cursor, sets the text color to white and empties the
// output register.
module text_console_cursor_engine import tcc_pkg::*; #(
  parameter int unsigned FONT_WIDTH  = 8,
  parameter int unsigned FONT_HEIGHT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tcc_in_if.sink                in_ch,
  tcc_out_if.source             out_ch
);

  tcc_cmd_t    cmd;
  tcc_status_t st;

  // sequencer
  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // cursor, geometry and output register
  tcc_dp #(
    .FONT_WIDTH  (FONT_WIDTH),
    .FONT_HEIGHT (FONT_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (in_ch.mode),
    .in_byte   (in_ch.text_byte),
    .out_ch    (out_ch)
  );

endmodule
